/* design/assert_macros.svh */
// Assertion macros, included by the core top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising edge, off while reset is high.
`define TSC_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Implication checked at every rising edge, off while reset is high.
`define TSC_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

/* design/tsc_pkg.sv */
// Types and constants of the tile stitch core.
package tsc_pkg;

  localparam int MAX_WIDTH  = 256;
  localparam int MAX_HEIGHT = 256;
  localparam int DEPTH      = MAX_WIDTH * MAX_HEIGHT;
  localparam int ADDR_W     = $clog2(DEPTH);

  typedef enum logic {
    OP_COMMIT = 1'b0,
    OP_READ   = 1'b1
  } op_t;

  typedef enum logic [0:0] {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } reg_idx_t;

  typedef struct packed {
    op_t         operation;
    logic [7:0]  tile_x0;
    logic [7:0]  tile_y0;
    logic [8:0]  tile_width;
    logic [8:0]  tile_height;
    logic [7:0]  offset_x;
    logic [7:0]  offset_y;
    logic [7:0]  class_label;
    logic [31:0] confidence_bits;
    logic [7:0]  read_x;
    logic [7:0]  read_y;
  } cmd_t;

  typedef struct packed {
    logic              accepted;
    logic              rejected;
    logic [7:0]        class_out;
    logic [31:0]       confidence_out;
    logic signed [7:0] priority_out;
  } rsp_t;

  // One stored pixel.
  typedef struct packed {
    logic signed [7:0] prio;
    logic [7:0]        cls;
    logic [31:0]       conf;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);
  localparam entry_t ENTRY_RESET = '{prio: -8'sd1, cls: 8'd0, conf: 32'd0};

  // Decoded item, handed from the decode stage to the update stage.
  typedef struct packed {
    op_t               op;
    logic              ok;
    logic [ADDR_W-1:0] addr;
    logic [6:0]        prio;
    logic [7:0]        cls;
    logic [31:0]       conf;
  } req_t;

endpackage

/* design/tsc_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module tsc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* design/tsc_decode.sv */
// Item decode: validity checks, edge-distance priority and store address.
module tsc_decode
  import tsc_pkg::*;
(
  input  cmd_t       cmd,
  input  logic [8:0] frame_width,
  input  logic [8:0] frame_height,
  output req_t       req
);

  logic [8:0] w_eff;
  logic [8:0] h_eff;
  logic [9:0] x_end;
  logic [9:0] y_end;
  logic [8:0] d_left;
  logic [8:0] d_right;
  logic [8:0] d_top;
  logic [8:0] d_bottom;
  logic [8:0] d_x;
  logic [8:0] d_y;
  logic [8:0] d_min;
  logic [7:0] col;
  logic [7:0] row;
  logic       commit_ok;
  logic       read_ok;

  always_comb begin
    w_eff = (32'(frame_width) > MAX_WIDTH) ? 9'(MAX_WIDTH) : frame_width;
    h_eff = (32'(frame_height) > MAX_HEIGHT) ? 9'(MAX_HEIGHT) : frame_height;

    x_end = 10'(cmd.tile_x0) + 10'(cmd.tile_width);
    y_end = 10'(cmd.tile_y0) + 10'(cmd.tile_height);
    commit_ok = (cmd.tile_width != 9'd0) && (cmd.tile_height != 9'd0) &&
                (x_end <= 10'(w_eff)) && (y_end <= 10'(h_eff)) &&
                (9'(cmd.offset_x) < cmd.tile_width) &&
                (9'(cmd.offset_y) < cmd.tile_height);
    read_ok = (9'(cmd.read_x) < w_eff) && (9'(cmd.read_y) < h_eff);

    // distance to the nearest tile edge
    d_left   = 9'(cmd.offset_x);
    d_right  = cmd.tile_width - 9'd1 - 9'(cmd.offset_x);
    d_top    = 9'(cmd.offset_y);
    d_bottom = cmd.tile_height - 9'd1 - 9'(cmd.offset_y);
    d_x   = (d_left < d_right) ? d_left : d_right;
    d_y   = (d_top < d_bottom) ? d_top : d_bottom;
    d_min = (d_x < d_y) ? d_x : d_y;

    if (cmd.operation == OP_COMMIT) begin
      col = cmd.tile_x0 + cmd.offset_x;
      row = cmd.tile_y0 + cmd.offset_y;
    end else begin
      col = cmd.read_x;
      row = cmd.read_y;
    end

    req.op   = cmd.operation;
    req.ok   = (cmd.operation == OP_COMMIT) ? commit_ok : read_ok;
    req.addr = ADDR_W'(32'(row) * MAX_WIDTH + 32'(col));
    req.prio = (d_min > 9'd127) ? 7'd127 : d_min[6:0];
    req.cls  = cmd.class_label;
    req.conf = cmd.confidence_bits;
  end

endmodule

/* design/tile_stitch_center_priority_core.sv */
// Top level of the tile stitch core: config, clear pass, update stage, response register.
// The decode result and the RAM read data are registered at the command beat; the update stage
//   loads the response register when it advances, which a held response can stall.
// Throughput: one command per cycle when no held response stalls, set by the single read and
//   write port of the pixel RAM; a same-pixel access after a commit uses a one-entry forward.
// Reset: frame_width and frame_height go to 0; the 65536 RAM entries are then swept one
//   entry a cycle to priority -1, class 0, confidence 0, with cmd_ready low; APB stays open.
module tile_stitch_center_priority_core
  import tsc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // command channel
  input  logic        cmd_valid,
  output logic        cmd_ready,
  input  cmd_t        cmd,
  // response channel
  output logic        rsp_valid,
  input  logic        rsp_ready,
  output rsp_t        rsp,
  // APB configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  `include "assert_macros.svh"

  // ---------------------------------------------------------------- config
  logic [8:0] frame_width;
  logic [8:0] frame_height;
  reg_idx_t   reg_idx;
  logic       cfg_wr;

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_t'(paddr[2]);
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= 9'd0;
      frame_height <= 9'd0;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_FRAME_WIDTH:  frame_width  <= pwdata[8:0];
        REG_FRAME_HEIGHT: frame_height <= pwdata[8:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_FRAME_WIDTH:  prdata = {23'd0, frame_width};
      REG_FRAME_HEIGHT: prdata = {23'd0, frame_height};
      default:          prdata = 32'd0;
    endcase
  end

  // ---------------------------------------------------------- clear pass
  // Runs once after reset; owns the RAM write port until the last entry.
  logic              clearing;
  logic [ADDR_W-1:0] clr_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + 1'b1;
      if (clr_addr == '1) begin
        clearing <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------- decode stage
  req_t req;
  logic cmd_beat;

  tsc_decode u_decode (
    .cmd          (cmd),
    .frame_width  (frame_width),
    .frame_height (frame_height),
    .req          (req)
  );

  // ---------------------------------------------------------- update stage
  logic   s1_valid;
  req_t   s1_req;
  logic   s1_advance;
  entry_t ram_rdata;
  entry_t stored;
  entry_t new_entry;
  logic   update;
  rsp_t   result;

  // last write, forwarded when the read raced it
  logic              fwd_valid;
  logic [ADDR_W-1:0] fwd_addr;
  entry_t            fwd_data;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  entry_t            ram_wdata;

  // The update stage never drops its RAM data: the read port is only
  // enabled on a command beat, and no beat is taken while it stalls.
  assign s1_advance = s1_valid && (!rsp_valid || rsp_ready);
  assign cmd_ready  = !clearing && (!s1_valid || s1_advance);
  assign cmd_beat   = cmd_valid && cmd_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (cmd_beat) begin
      s1_valid <= 1'b1;
    end else if (s1_advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_beat) begin
      s1_req <= req;
    end
  end

  always_comb begin
    stored = (fwd_valid && (fwd_addr == s1_req.addr)) ? fwd_data : ram_rdata;
    update = (s1_req.op == OP_COMMIT) && s1_req.ok &&
             ($signed({1'b0, s1_req.prio}) > stored.prio);

    new_entry.prio = $signed({1'b0, s1_req.prio});
    new_entry.cls  = s1_req.cls;
    new_entry.conf = s1_req.conf;

    result.accepted = update;
    result.rejected = !s1_req.ok;
    if ((s1_req.op == OP_READ) && s1_req.ok) begin
      result.class_out      = stored.cls;
      result.confidence_out = stored.conf;
      result.priority_out   = stored.prio;
    end else begin
      result.class_out      = 8'd0;
      result.confidence_out = 32'd0;
      result.priority_out   = 8'sd0;
    end

    if (clearing) begin
      ram_we    = 1'b1;
      ram_waddr = clr_addr;
      ram_wdata = ENTRY_RESET;
    end else begin
      ram_we    = s1_advance && update;
      ram_waddr = s1_req.addr;
      ram_wdata = new_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_valid <= 1'b0;
    end else if (!clearing && s1_advance && update) begin
      fwd_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!clearing && s1_advance && update) begin
      fwd_addr <= s1_req.addr;
      fwd_data <= new_entry;
    end
  end

  tsc_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (DEPTH)
  ) u_pixel_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (cmd_beat),
    .raddr (req.addr),
    .rdata (ram_rdata)
  );

  // ------------------------------------------------------ response register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (s1_advance) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance) begin
      rsp <= result;
    end
  end

  // ------------------------------------------------------------ assertions
  `TSC_ASSERT_IMPL(a_clear_idle, clk, rst, clearing, !s1_valid && !rsp_valid,
    "item in flight during clear pass")
  `TSC_ASSERT_IMPL(a_rsp_flags, clk, rst, rsp_valid, !(rsp.accepted && rsp.rejected),
    "response both accepted and rejected")
  `TSC_ASSERT_IMPL(a_commit_zero, clk, rst, rsp_valid && rsp.accepted,
    rsp.class_out == 8'd0 && rsp.confidence_out == 32'd0 && rsp.priority_out == 8'sd0,
    "commit response carries pixel data")
  `TSC_ASSERT_IMPL(a_beat_to_stage, clk, rst, cmd_beat, ##1 s1_valid,
    "command beat did not reach the update stage")

endmodule
